/* src/tswb_pkg.sv */
// ----------------------------------------------------------------------------
// tswb_pkg
// Shared types and constants for the timed square-wave beeper: beat payloads,
// function codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tswb_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    // Reciprocal of ten for 16-bit operands: (x * RECIP_TEN) >> RECIP_SHIFT.
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] freq_hz;
        logic [14:0] duration;
    } in_t;

    typedef struct packed {
        logic        pin_level;
        logic        playing;
        logic [15:0] periods_left;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
        logic do_tick;
        logic do_stop;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

/* src/tswb_ctrl.sv */
// ----------------------------------------------------------------------------
// tswb_ctrl
// Controller: accepts input beats, sequences the reload divider and the
// period count for a start, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tswb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        in_func,
    output logic              m_valid,
    input  logic              m_ready,
    output tswb_pkg::cmd_t    cmd,
    input  tswb_pkg::status_t status
);

    tswb_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept;

    assign s_ready = (state_reg == tswb_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tswb_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            tswb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_func == tswb_pkg::FUNC_START) begin
                        cmd.load   = 1'b1;
                        state_next = tswb_pkg::ST_DIV;
                    end else begin
                        cmd.do_tick  = (in_func == tswb_pkg::FUNC_TICK);
                        cmd.do_stop  = (in_func == tswb_pkg::FUNC_STOP);
                        cmd.out_load = 1'b1;
                    end
                end
            end
            tswb_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = tswb_pkg::ST_COMMIT;
                end
            end
            tswb_pkg::ST_COMMIT: begin
                cmd.commit   = 1'b1;
                cmd.out_load = 1'b1;
                state_next   = tswb_pkg::ST_IDLE;
            end
            default: begin
                state_next = tswb_pkg::ST_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

`ifndef ASSERT_OFF
    // A start is busy until its result is loaded, so no beat can overlap it.
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != tswb_pkg::ST_IDLE) |-> !s_ready)
        else $error("input accepted while a start is in progress");

    // A loaded result must be presented on the next cycle.
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("result loaded but not presented");
`endif

endmodule

/* src/tswb_datapath.sv */
// ----------------------------------------------------------------------------
// tswb_datapath
// Datapath: frequency clamp, restoring divider for the reload value, period
// count multiply with saturation, tone timer and the result register.
// ----------------------------------------------------------------------------
module tswb_datapath #(
    parameter int TICK_RATE_HZ = 31250,
    parameter int TIMER_BITS   = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tswb_pkg::in_t     in_data,
    input  tswb_pkg::cmd_t    cmd,
    output tswb_pkg::status_t status,
    output tswb_pkg::out_t    out_data
);

    localparam int HZ_HI     = TICK_RATE_HZ / 2;
    localparam int SPAN      = 1 << TIMER_BITS;
    localparam int HZ_LO_RAW = HZ_HI / SPAN;
    localparam int HZ_LO     = (HZ_LO_RAW == 0) ? 1 : HZ_LO_RAW;
    localparam int NB        = $clog2(HZ_HI + 1);
    localparam int SW        = $clog2(NB);
    localparam int QW        = (NB > TIMER_BITS + 1) ? NB : TIMER_BITS + 1;

    logic [15:0]           hz_reg, hz_next;
    logic [14:0]           dur_reg, dur_next;
    logic [15:0]           rem_reg, rem_next;
    logic [NB-1:0]         quo_reg, quo_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [12:0]           tenth_reg, tenth_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [TIMER_BITS-1:0] reload_reg, reload_next;
    logic [15:0]           remain_reg, remain_next;
    logic                  level_reg, level_next;
    logic                  active_reg, active_next;
    tswb_pkg::out_t        out_reg, out_next;

    logic [31:0]           freq_ext;
    logic [16:0]           trial;
    logic [16:0]           trial_diff;
    logic                  trial_ge;
    logic [31:0]           tenth_prod;
    logic [QW-1:0]         q_ext, q_sat, reload_diff;
    logic [27:0]           count_prod;
    logic [15:0]           count_sat;

    assign freq_ext   = {16'd0, in_data.freq_hz};
    assign trial      = {rem_reg, quo_reg[NB-1]};
    assign trial_ge   = trial >= {1'b0, hz_reg};
    assign trial_diff = trial - {1'b0, hz_reg};
    assign tenth_prod = {16'd0, hz_reg} * {16'd0, tswb_pkg::RECIP_TEN};
    assign q_ext      = QW'(quo_reg);
    assign q_sat      = (q_ext > QW'(SPAN)) ? QW'(SPAN) : q_ext;
    assign reload_diff = QW'(SPAN) - q_sat;
    assign count_prod = {15'd0, tenth_reg} * {13'd0, dur_reg};
    assign count_sat  = (|count_prod[27:16]) ? 16'hFFFF : count_prod[15:0];

    assign status.div_last = (step_reg == '0);
    assign out_data        = out_reg;

    always_comb begin
        hz_next     = hz_reg;
        dur_next    = dur_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        tenth_next  = tenth_reg;
        timer_next  = timer_reg;
        reload_next = reload_reg;
        remain_next = remain_reg;
        level_next  = level_reg;
        active_next = active_reg;
        out_next    = out_reg;

        if (cmd.load) begin
            if (freq_ext < 32'(HZ_LO)) begin
                hz_next = 16'(HZ_LO);
            end else if (freq_ext > 32'(HZ_HI)) begin
                hz_next = 16'(HZ_HI);
            end else begin
                hz_next = in_data.freq_hz;
            end
            dur_next  = in_data.duration;
            rem_next  = '0;
            quo_next  = NB'(HZ_HI);
            step_next = SW'(NB - 1);
        end

        if (cmd.div_step) begin
            rem_next   = trial_ge ? trial_diff[15:0] : trial[15:0];
            quo_next   = {quo_reg[NB-2:0], trial_ge};
            step_next  = step_reg - 1'b1;
            tenth_next = tenth_prod[31:tswb_pkg::RECIP_SHIFT];
        end

        if (cmd.commit) begin
            reload_next = reload_diff[TIMER_BITS-1:0];
            timer_next  = reload_diff[TIMER_BITS-1:0];
            remain_next = count_sat;
            level_next  = 1'b0;
            active_next = (count_sat != 16'd0);
        end

        if (cmd.do_tick && active_reg) begin
            if (timer_reg == '1) begin
                timer_next = reload_reg;
                level_next = !level_reg;
                if (level_reg) begin
                    remain_next = remain_reg - 16'd1;
                    if (remain_reg == 16'd1) begin
                        active_next = 1'b0;
                    end
                end
            end else begin
                timer_next = timer_reg + 1'b1;
            end
        end

        if (cmd.do_stop) begin
            active_next = 1'b0;
            level_next  = 1'b0;
        end

        if (cmd.out_load) begin
            out_next.pin_level    = level_next;
            out_next.playing      = active_next;
            out_next.periods_left = remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg  <= '0;
            reload_reg <= '0;
            remain_reg <= '0;
            level_reg  <= 1'b0;
            active_reg <= 1'b0;
            step_reg   <= '0;
        end else begin
            timer_reg  <= timer_next;
            reload_reg <= reload_next;
            remain_reg <= remain_next;
            level_reg  <= level_next;
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        hz_reg    <= hz_next;
        dur_reg   <= dur_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        tenth_reg <= tenth_next;
        out_reg   <= out_next;
    end

`ifndef ASSERT_OFF
    // A playing tone always has at least one period left.
    a_active_count: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (remain_reg != 16'd0))
        else $error("tone active with no periods left");

    // A stop silences the pin and halts the tone.
    a_stop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_stop |=> (!active_reg && !level_reg))
        else $error("stop did not silence the output");

    // Ticks while idle leave the timer untouched.
    a_idle_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.do_tick && !active_reg) |=> $stable(timer_reg))
        else $error("timer moved while idle");
`endif

endmodule

/* src/timed_square_wave_beeper_core.sv */
// ----------------------------------------------------------------------------
// timed_square_wave_beeper_core
// Square-wave tone generator advanced by a prescaled tick, with timed play.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat with the pin level, the
// playing flag and the periods left after that beat is applied. Tick, stop
// and unused codes stream one per cycle while the result side keeps up. For
// a start, the reload value comes from a restoring divider over NB quotient
// bits, where NB is the bit width of TICK_RATE_HZ / 2, that produces one
// quotient bit per cycle, followed by a commit step for the period count
// multiply. No new beat is taken while a start is in progress or while a
// result waits to be taken.
module timed_square_wave_beeper_core #(
    parameter int TICK_RATE_HZ = 31250,
    parameter int TIMER_BITS   = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tswb_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tswb_pkg::out_t m_data
);

    tswb_pkg::cmd_t    cmd;
    tswb_pkg::status_t status;

    tswb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_func (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    tswb_datapath #(
        .TICK_RATE_HZ (TICK_RATE_HZ),
        .TIMER_BITS   (TIMER_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_data)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for timed_square_wave_beeper_core. A behavioral tone
// generator in the bench predicts the pin level, the playing flag and the
// periods left for every accepted input beat, and each result beat is
// compared with the oldest prediction. Directed tests cover the idle block,
// the frequency clamps, silence, restart, stop and a tone that plays out to
// its end. Random start/tick sequences then run under four handshake
// pressure phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TICK_RATE_HZ = 31250;
    localparam int TIMER_BITS   = 8;
    localparam int HALF_RATE    = TICK_RATE_HZ / 2;
    localparam int TIMER_SPAN   = 1 << TIMER_BITS;
    localparam int TIMER_TOP    = TIMER_SPAN - 1;
    localparam int HZ_FLOOR     = (HALF_RATE / TIMER_SPAN > 0) ? HALF_RATE / TIMER_SPAN : 1;
    localparam int HZ_CEIL      = (HALF_RATE > 0) ? HALF_RATE : 1;
    localparam longint PERIODS_MAX = 65535;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tswb_pkg::in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tswb_pkg::out_t m_data;

    logic [TIMER_BITS-1:0] tone_timer  = '0;
    logic [TIMER_BITS-1:0] tone_reload = '0;
    logic [15:0]           tone_periods = '0;
    logic                  tone_level  = 1'b0;
    logic                  tone_active = 1'b0;

    tswb_pkg::out_t pending_status[$];
    tswb_pkg::out_t status_due;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   fail_count     = 0;

    timed_square_wave_beeper_core #(
        .TICK_RATE_HZ(TICK_RATE_HZ),
        .TIMER_BITS  (TIMER_BITS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic tswb_pkg::out_t predict_tone_status(input tswb_pkg::in_t b);
        int             hz;
        int             divisor;
        longint         periods;
        tswb_pkg::out_t r;
        case (b.func)
            tswb_pkg::FUNC_TICK: begin
                if (tone_active) begin
                    if (tone_timer >= TIMER_TOP) begin
                        tone_timer = tone_reload;
                        tone_level = ~tone_level;
                        if (!tone_level) begin
                            tone_periods = tone_periods - 16'd1;
                            if (tone_periods == 16'd0) tone_active = 1'b0;
                        end
                    end else begin
                        tone_timer = tone_timer + 1'b1;
                    end
                end
            end
            tswb_pkg::FUNC_START: begin
                hz = int'(b.freq_hz);
                if (hz < HZ_FLOOR) hz = HZ_FLOOR;
                if (hz > HZ_CEIL) hz = HZ_CEIL;
                divisor = HALF_RATE / hz;
                if (divisor > TIMER_SPAN) divisor = TIMER_SPAN;
                tone_reload = TIMER_BITS'(TIMER_SPAN - divisor);
                periods = longint'(hz / 10) * longint'(b.duration);
                if (periods > PERIODS_MAX) periods = PERIODS_MAX;
                tone_periods = 16'(periods);
                tone_timer   = tone_reload;
                tone_level   = 1'b0;
                tone_active  = (tone_periods != 16'd0);
            end
            tswb_pkg::FUNC_STOP: begin
                tone_active = 1'b0;
                tone_level  = 1'b0;
            end
            default: begin
            end
        endcase
        r.pin_level    = tone_level;
        r.playing      = tone_active;
        r.periods_left = tone_periods;
        return r;
    endfunction

    task automatic send_op(input logic [1:0] f, input logic [15:0] hz, input logic [14:0] dur);
        tswb_pkg::in_t b;
        b.func     = f;
        b.freq_hz  = hz;
        b.duration = dur;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_status.push_back(predict_tone_status(b));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $error("result beat with no prediction waiting: %p", m_data);
                fail_count++;
            end else begin
                status_due = pending_status.pop_front();
                if (m_data.pin_level !== status_due.pin_level) begin
                    $error("pin_level: expected %0d, got %0d",
                           status_due.pin_level, m_data.pin_level);
                    fail_count++;
                end
                if (m_data.playing !== status_due.playing) begin
                    $error("playing: expected %0d, got %0d",
                           status_due.playing, m_data.playing);
                    fail_count++;
                end
                if (m_data.periods_left !== status_due.periods_left) begin
                    $error("periods_left: expected %0d, got %0d",
                           status_due.periods_left, m_data.periods_left);
                    fail_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic test_idle_block();
        send_op(tswb_pkg::FUNC_TICK, 16'h0000, 15'h0000);
        send_op(tswb_pkg::FUNC_STOP, 16'h1234, 15'h0567);
        send_op(FUNC_UNUSED, 16'hFFFF, 15'h7FFF);
    endtask

    task automatic test_frequency_limits();
        send_op(tswb_pkg::FUNC_START, 16'h0000, 15'd1);
        send_op(tswb_pkg::FUNC_TICK, 16'h0000, 15'h0000);
        send_op(tswb_pkg::FUNC_START, 16'(HZ_FLOOR - 1), 15'h7FFF);
        send_op(tswb_pkg::FUNC_TICK, 16'h0000, 15'h0000);
        send_op(tswb_pkg::FUNC_START, 16'(HZ_FLOOR), 15'd1);
        send_op(tswb_pkg::FUNC_START, 16'(HZ_FLOOR + 1), 15'd7);
        send_op(tswb_pkg::FUNC_TICK, 16'hFFFF, 15'h7FFF);
        send_op(tswb_pkg::FUNC_START, 16'(HZ_CEIL), 15'h7FFF);
        repeat (3) send_op(tswb_pkg::FUNC_TICK, 16'h0000, 15'h0000);
        send_op(tswb_pkg::FUNC_START, 16'(HZ_CEIL + 1), 15'd3);
        send_op(tswb_pkg::FUNC_TICK, 16'h0000, 15'h0000);
        send_op(tswb_pkg::FUNC_START, 16'hFFFF, 15'h7FFF);
        send_op(tswb_pkg::FUNC_TICK, 16'h0000, 15'h0000);
        send_op(tswb_pkg::FUNC_START, 16'd1000, 15'd0);
        send_op(tswb_pkg::FUNC_TICK, 16'h0000, 15'h0000);
    endtask

    task automatic test_restart_and_stop();
        send_op(tswb_pkg::FUNC_START, 16'd440, 15'd3);
        repeat (3) send_op(tswb_pkg::FUNC_TICK, 16'h0000, 15'h0000);
        send_op(tswb_pkg::FUNC_START, 16'(HZ_CEIL), 15'd2);
        send_op(tswb_pkg::FUNC_TICK, 16'h0000, 15'h0000);
        send_op(tswb_pkg::FUNC_STOP, 16'h0000, 15'h0000);
        send_op(tswb_pkg::FUNC_TICK, 16'h0000, 15'h0000);
    endtask

    // The shortest complete tone needs a few thousand ticks at any frequency.
    task automatic test_tone_runs_out();
        send_op(tswb_pkg::FUNC_START, 16'(HZ_CEIL), 15'd1);
        while (tone_active) send_op(tswb_pkg::FUNC_TICK, 16'($urandom), 15'($urandom));
        repeat (3) send_op(tswb_pkg::FUNC_TICK, 16'($urandom), 15'($urandom));
    endtask

    task automatic test_random_traffic(input int beats, input int send_pct, input int recv_pct);
        int          beats_left;
        int          burst;
        logic [15:0] hz;
        logic [14:0] dur;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        beats_left     = beats;
        while (beats_left > 0) begin
            if ($urandom_range(0, 99) < 75) begin
                case ($urandom_range(0, 3))
                    0: hz = 16'($urandom);
                    1: hz = 16'($urandom_range(0, 70));
                    2: hz = 16'($urandom_range(15000, 16000));
                    default: hz = 16'($urandom_range(100, 5000));
                endcase
                case ($urandom_range(0, 2))
                    0: dur = 15'($urandom);
                    1: dur = 15'($urandom_range(0, 3));
                    default: dur = 15'($urandom_range(0, 100));
                endcase
                send_op(tswb_pkg::FUNC_START, hz, dur);
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
                                                     : $urandom_range(1, 60);
                repeat (burst) send_op(tswb_pkg::FUNC_TICK, 16'($urandom), 15'($urandom));
                beats_left -= burst + 1;
                if ($urandom_range(0, 2) == 0) begin
                    send_op(tswb_pkg::FUNC_STOP, 16'($urandom), 15'($urandom));
                    beats_left--;
                end
            end else begin
                send_op(2'($urandom_range(0, 3)), 16'($urandom), 15'($urandom));
                beats_left--;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_block();
        test_frequency_limits();
        test_restart_and_stop();
        test_tone_runs_out();
        test_random_traffic(275, 0, 0);
        test_random_traffic(275, 67, 0);
        test_random_traffic(275, 0, 67);
        test_random_traffic(275, 8, 8);
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* timed_square_wave_beeper_core.f */
src/tswb_pkg.sv
src/tswb_ctrl.sv
src/tswb_datapath.sv
src/timed_square_wave_beeper_core.sv
tb/testbench.sv
